// ===== design/sfmh_pkg.sv =====
// shared types for the symbol frequency min-heap
// no dependencies
package sfmh_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_INC,
    ST_RM_RD,
    ST_RM_MOVE,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DN_WR,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_OUT
  } sfmh_state_t;

  localparam logic FUNC_COUNT  = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

endpackage

// ===== design/symbol_frequency_min_heap.sv =====
// symbol frequency min-heap top level; depends on sfmh_pkg
// count op scans the slots one by one, then sifts up per level (new symbol) or down
//   (existing symbol); remove reads the root and the last entry, then sifts down; a
//   root read and the result state follow
// throughput: one beat in flight, in_stall high from accept until the result is taken
// reset: entry count and control clear; heap slots are undefined until written
module symbol_frequency_min_heap #(
  parameter int SYMBOL_BITS = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [SYMBOL_BITS-1:0] in_symbol,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SYMBOL_BITS-1:0] out_removed_symbol,
  output logic [COUNT_BITS-1:0]  out_removed_count,
  output logic [SYMBOL_BITS-1:0] out_min_symbol,
  output logic [COUNT_BITS-1:0]  out_min_count,
  output logic [SYMBOL_BITS:0]   out_entry_total,
  output logic                   out_empty_error
);

  localparam int DEPTH = 1 << SYMBOL_BITS;
  localparam int AW    = SYMBOL_BITS;
  localparam int NW    = SYMBOL_BITS + 1;
  localparam int EW    = SYMBOL_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // slot memory: {symbol, count}
  logic [EW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  sfmh_pkg::sfmh_state_t state_r, state_nxt;

  logic [NW-1:0]          n_r, n_nxt;          // entry count
  logic [NW-1:0]          pos_r, pos_nxt;      // current slot (scan index or sift slot)
  logic [NW-1:0]          kid_r, kid_nxt;      // child being looked at
  logic [EW-1:0]          cur_r, cur_nxt;      // entry being sifted
  logic [EW-1:0]          best_r, best_nxt;    // best child so far
  logic [NW-1:0]          best_i_r, best_i_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [EW-1:0]          rem_r, rem_nxt;
  logic                   err_r, err_nxt;

  logic [COUNT_BITS-1:0]  rd_cnt, cur_cnt, best_cnt;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [NW:0]            left_w;
  logic [NW-1:0]          parent_w;

  assign rd_cnt   = rd_data_r[COUNT_BITS-1:0];
  assign rd_sym   = rd_data_r[EW-1:COUNT_BITS];
  assign cur_cnt  = cur_r[COUNT_BITS-1:0];
  assign best_cnt = best_r[COUNT_BITS-1:0];
  assign left_w   = {pos_r, 1'b1};
  assign parent_w = (pos_r - NW'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfmh_pkg::ST_IDLE;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    kid_r    <= kid_nxt;
    cur_r    <= cur_nxt;
    best_r   <= best_nxt;
    best_i_r <= best_i_nxt;
    sym_r    <= sym_nxt;
    rem_r    <= rem_nxt;
    err_r    <= err_nxt;
  end

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    pos_nxt    = pos_r;
    kid_nxt    = kid_r;
    cur_nxt    = cur_r;
    best_nxt   = best_r;
    best_i_nxt = best_i_r;
    sym_nxt    = sym_r;
    rem_nxt    = rem_r;
    err_nxt    = err_r;
    rd_addr    = pos_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = pos_r[AW-1:0];
    wr_data    = cur_r;
    unique case (state_r)
      sfmh_pkg::ST_IDLE: begin
        // keep the root on the read port so a remove finds it next cycle
        rd_addr = '0;
        if (in_valid) begin
          sym_nxt  = in_symbol;
          rem_nxt  = '0;
          err_nxt  = 1'b0;
          pos_nxt  = '0;
          if (in_func == sfmh_pkg::FUNC_REMOVE) begin
            if (n_r == '0) begin
              err_nxt   = 1'b1;
              state_nxt = sfmh_pkg::ST_ROOT_RD;
            end else begin
              state_nxt = sfmh_pkg::ST_RM_RD;
            end
          end else begin
            state_nxt = sfmh_pkg::ST_SCAN_RD;
          end
        end
      end
      sfmh_pkg::ST_SCAN_RD: begin
        if (pos_r == n_r) begin
          // new symbol: append at the end and sift up, unless the heap is full
          if (n_r[NW-1]) begin
            state_nxt = sfmh_pkg::ST_ROOT_RD;
          end else begin
            cur_nxt   = {sym_r, COUNT_BITS'(1)};
            n_nxt     = n_r + NW'(1);
            state_nxt = sfmh_pkg::ST_UP_RD;
          end
        end else begin
          state_nxt = sfmh_pkg::ST_SCAN_CMP;
        end
      end
      sfmh_pkg::ST_SCAN_CMP: begin
        if (rd_sym == sym_r) begin
          state_nxt = sfmh_pkg::ST_INC;
          cur_nxt   = {rd_sym, (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1)};
        end else begin
          pos_nxt   = pos_r + NW'(1);
          state_nxt = sfmh_pkg::ST_SCAN_RD;
        end
      end
      sfmh_pkg::ST_INC: begin
        state_nxt = sfmh_pkg::ST_DN_RD;
        kid_nxt   = left_w[NW-1:0];
      end
      sfmh_pkg::ST_RM_RD: begin
        // memory holds root now; fetch last entry next
        rem_nxt   = rd_data_r;
        rd_addr   = AW'(n_r - NW'(1));
        n_nxt     = n_r - NW'(1);
        state_nxt = sfmh_pkg::ST_RM_MOVE;
      end
      sfmh_pkg::ST_RM_MOVE: begin
        cur_nxt   = rd_data_r;
        pos_nxt   = '0;
        kid_nxt   = NW'(1);
        state_nxt = (n_r == '0) ? sfmh_pkg::ST_ROOT_RD : sfmh_pkg::ST_DN_RD;
      end
      sfmh_pkg::ST_DN_RD: begin
        // kid_r is left child; read it, best starts as the parent itself
        rd_addr    = kid_r[AW-1:0];
        best_nxt   = cur_r;
        best_i_nxt = pos_r;
        if (left_w >= {1'b0, n_r}) begin
          wr_en     = 1'b1;
          state_nxt = sfmh_pkg::ST_ROOT_RD;
        end else begin
          state_nxt = sfmh_pkg::ST_DN_CMP;
        end
      end
      sfmh_pkg::ST_DN_CMP: begin
        // one child compare per visit
        if (rd_cnt < best_cnt) begin
          best_nxt   = rd_data_r;
          best_i_nxt = kid_r;
        end
        if (kid_r[0] && (kid_r + NW'(1) < n_r)) begin
          rd_addr = AW'(kid_r + NW'(1));
          kid_nxt = kid_r + NW'(1);
        end else begin
          state_nxt = sfmh_pkg::ST_DN_WR;
        end
      end
      sfmh_pkg::ST_DN_WR: begin
        wr_en = 1'b1;
        if (best_i_r == pos_r) begin
          state_nxt = sfmh_pkg::ST_ROOT_RD;
        end else begin
          wr_data   = best_r;
          pos_nxt   = best_i_r;
          kid_nxt   = {best_i_r[NW-2:0], 1'b1};
          state_nxt = sfmh_pkg::ST_DN_RD;
        end
      end
      sfmh_pkg::ST_UP_RD: begin
        rd_addr = parent_w[AW-1:0];
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = sfmh_pkg::ST_ROOT_RD;
        end else begin
          state_nxt = sfmh_pkg::ST_UP_CMP;
        end
      end
      sfmh_pkg::ST_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_cnt > cur_cnt) begin
          wr_data   = rd_data_r;
          pos_nxt   = parent_w;
          state_nxt = sfmh_pkg::ST_UP_RD;
        end else begin
          state_nxt = sfmh_pkg::ST_ROOT_RD;
        end
      end
      sfmh_pkg::ST_ROOT_RD: begin
        rd_addr   = '0;
        state_nxt = sfmh_pkg::ST_OUT;
      end
      sfmh_pkg::ST_OUT: begin
        // root stays on the read port while the result waits
        rd_addr = '0;
        if (!out_stall) begin
          state_nxt = sfmh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfmh_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state_r != sfmh_pkg::ST_IDLE);
    out_valid = (state_r == sfmh_pkg::ST_OUT);
  end

  assign out_removed_symbol = rem_r[EW-1:COUNT_BITS];
  assign out_removed_count  = rem_r[COUNT_BITS-1:0];
  assign out_min_symbol     = (n_r == '0) ? '0 : rd_data_r[EW-1:COUNT_BITS];
  assign out_min_count      = (n_r == '0) ? '0 : rd_data_r[COUNT_BITS-1:0];
  assign out_entry_total    = n_r;
  assign out_empty_error    = err_r;

`ifndef SYNTHESIS
  // entry count never exceeds the slot count
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(DEPTH)) else $error("entry count overflow");
  // an empty-heap error leaves the count at zero
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_error |-> out_entry_total == '0) else $error("error with entries");
  // a stalled result stays valid with the count unchanged
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(n_r)) else $error("result dropped");
  // a beat taken while idle does not raise out_valid at once
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid) else $error("accept while busy");
`endif

endmodule
